>>> design/hmsn_pkg.sv
// Shared types, constants and helpers of the heightmap sampler and normal unit.
// No dependencies; every other design file but hmsn_ram imports this package.
package hmsn_pkg;

  // grid and field sizes
  localparam int MAX_DIM    = 256;
  localparam int MIN_DIM    = 2;
  localparam int DIM_W      = 9;
  localparam int OP_W       = 2;
  localparam int CRD_W      = 16;
  localparam int HGT_W      = 16;
  localparam int CELL_W     = 8;
  localparam int FRAC_W     = 8;
  localparam int ONE_Q8     = 256;
  localparam int IN_W       = 56;
  localparam int OUT_W      = 64;
  localparam int USER_W     = 2;

  // four banks split by the low bits of row and column
  localparam int BANKS      = 4;
  localparam int BANK_AW    = 2 * (CELL_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // front-to-back queue
  localparam int Q_DEPTH    = 4;
  localparam int QP_W       = $clog2(Q_DEPTH);

  // normal arithmetic
  localparam int VEC_W      = 19;
  localparam int MAG_W      = 18;
  localparam int VY_W       = 11;
  localparam int SQR_W      = 2 * MAG_W;
  localparam int LEN_W      = SQR_W + 2;
  localparam int SQ_N       = 27;
  localparam int RAD_PAD    = 2 * SQ_N - LEN_W;
  localparam int SQ_REM_W   = SQ_N + 2;
  localparam int NORM_SHIFT = 22;
  localparam int NUM_W      = MAG_W + NORM_SHIFT + 1;
  localparam int DIV_N      = 16;
  localparam int DREM_W     = SQ_N + 1;
  localparam int Q14_ONE    = 16384;
  localparam int SB_N       = SQ_N + DIV_N + 1;

  // operation codes on the input channel
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_NORMAL = 2'd2;

  // configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_WRITE,
    KIND_SAMPLE,
    KIND_NORMAL
  } kind_t;

  // classified item as it sits in the queue
  typedef struct packed {
    kind_t              kind;
    logic [CELL_W-1:0]  x;
    logic [CELL_W-1:0]  y;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
    logic               x_alt;
    logic               y_alt;
    logic               oor;
    logic               border;
    logic               zero_pt;
    logic               has_w;
    logic               has_e;
    logic               has_s;
    logic               has_n;
    logic [HGT_W-1:0]   hv;
  } cls_t;

  // sideband that travels beside the arithmetic
  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic              oor;
    logic              zero_pt;
    logic              border;
    logic [HGT_W-1:0]  height;
  } tag_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_W'(MIN_DIM)) return DIM_W'(MIN_DIM);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

endpackage

>>> design/hmsn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hmsn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/hmsn_front.sv
// Front end: decodes an input item into a classified queue entry.
// Depends on hmsn_pkg.
module hmsn_front import hmsn_pkg::*; (
  input  logic [DIM_W-1:0] grid_width,
  input  logic [DIM_W-1:0] grid_height,
  input  logic [OP_W-1:0]  op,
  input  logic [CRD_W-1:0] cx,
  input  logic [CRD_W-1:0] cy,
  input  logic [HGT_W-1:0] hv,
  output cls_t             item
);

  logic [CELL_W-1:0] x, y;
  logic              x_edge, y_edge;

  assign x = cx[CRD_W-1:FRAC_W];
  assign y = cy[CRD_W-1:FRAC_W];
  assign x_edge = ({1'b0, x} == grid_width - DIM_W'(1));
  assign y_edge = ({1'b0, y} == grid_height - DIM_W'(1));

  // classify position and operation
  always_comb begin
    item.x       = x;
    item.y       = y;
    item.fx      = cx[FRAC_W-1:0];
    item.fy      = cy[FRAC_W-1:0];
    item.hv      = hv;
    item.oor     = ({1'b0, x} >= grid_width) || ({1'b0, y} >= grid_height);
    item.border  = x_edge || y_edge;
    item.zero_pt = (cx == '0) || (cy == '0);
    item.x_alt   = !x_edge;
    item.y_alt   = !y_edge;
    item.has_w   = (y != '0);
    item.has_e   = !y_edge;
    item.has_s   = (x != '0);
    item.has_n   = !x_edge;
    case (op)
      OP_WRITE:  item.kind = item.oor ? KIND_NOP : KIND_WRITE;
      OP_SAMPLE: item.kind = KIND_SAMPLE;
      OP_NORMAL: item.kind = KIND_NORMAL;
      default:   item.kind = KIND_NOP;
    endcase
  end

endmodule

>>> design/hmsn_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on hmsn_pkg.
module hmsn_queue import hmsn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_item,
  output logic full,
  input  logic pop,
  output logic valid,
  output cls_t head
);

  cls_t            mem_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QP_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QP_W+1)'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

>>> design/hmsn_norm.sv
// Normalizing pipeline: squares, pipelined integer square root and three
// pipelined restoring dividers. Depends on hmsn_pkg.
module hmsn_norm import hmsn_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [VEC_W-1:0] vx,
  input  logic [VY_W-1:0]         vy,
  input  logic signed [VEC_W-1:0] vz,
  output logic signed [HGT_W-1:0] nx,
  output logic signed [HGT_W-1:0] ny,
  output logic signed [HGT_W-1:0] nz
);

  logic signed [VEC_W-1:0] vx_a_r, vz_a_r;
  logic [VY_W-1:0]         vy_a_r;
  logic [VEC_W-1:0]        absx, absz;
  logic [MAG_W-1:0]        mx, mz;
  logic [SQR_W-1:0]        sqx_b_r, sqy_b_r, sqz_b_r;
  logic [3*MAG_W-1:0]      mag_b_r, mag_c_r;
  logic [2:0]              sgn_b_r, sgn_c_r;
  logic [LEN_W-1:0]        len2_c_r;

  logic [SQ_REM_W-1:0]     sq_rem  [0:SQ_N];
  logic [SQ_N-1:0]         sq_root [0:SQ_N];
  logic [2*SQ_N-1:0]       sq_rad  [0:SQ_N];
  logic [3*MAG_W-1:0]      sq_mag  [0:SQ_N];
  logic [2:0]              sq_sgn  [0:SQ_N];

  logic [DREM_W-1:0]       dv_rem [0:DIV_N][0:2];
  logic [DIV_N-1:0]        dv_low [0:DIV_N][0:2];
  logic [DIV_N-1:0]        dv_q   [0:DIV_N][0:2];
  logic [SQ_N-1:0]         dv_div [0:DIV_N];
  logic [2:0]              dv_sgn [0:DIV_N];

  // take the raw vector
  always_ff @(posedge clk) begin
    if (en) begin
      vx_a_r <= vx;
      vy_a_r <= vy;
      vz_a_r <= vz;
    end
  end

  // magnitudes and squares
  assign absx = vx_a_r[VEC_W-1] ? (~vx_a_r + 1'b1) : vx_a_r;
  assign absz = vz_a_r[VEC_W-1] ? (~vz_a_r + 1'b1) : vz_a_r;
  assign mx   = absx[MAG_W-1:0];
  assign mz   = absz[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_b_r <= mx * mx;
      sqy_b_r <= SQR_W'(vy_a_r) * SQR_W'(vy_a_r);
      sqz_b_r <= mz * mz;
      mag_b_r <= {mz, MAG_W'(vy_a_r), mx};
      sgn_b_r <= {vz_a_r[VEC_W-1], 1'b0, vx_a_r[VEC_W-1]};
    end
  end

  // squared length
  always_ff @(posedge clk) begin
    if (en) begin
      len2_c_r <= LEN_W'(sqx_b_r) + LEN_W'(sqy_b_r) + LEN_W'(sqz_b_r);
      mag_c_r  <= mag_b_r;
      sgn_c_r  <= sgn_b_r;
    end
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = {len2_c_r, RAD_PAD'(0)};
  assign sq_mag[0]  = mag_c_r;
  assign sq_sgn[0]  = sgn_c_r;

  // square root, one result bit per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [SQ_REM_W-1:0] rem_t, trial;
    logic                ge;
    assign rem_t = {sq_rem[k][SQ_REM_W-3:0], sq_rad[k][2*SQ_N-1 -: 2]};
    assign trial = {sq_root[k], 2'b01};
    assign ge    = (rem_t >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k+1]  <= ge ? (rem_t - trial) : rem_t;
        sq_root[k+1] <= {sq_root[k][SQ_N-2:0], ge};
        sq_rad[k+1]  <= sq_rad[k] << 2;
        sq_mag[k+1]  <= sq_mag[k];
        sq_sgn[k+1]  <= sq_sgn[k];
      end
    end
  end

  // set up rounded dividends
  for (genvar i = 0; i < 3; i++) begin : g_setup
    logic [NUM_W-1:0] num;
    assign num = {1'b0, sq_mag[SQ_N][i*MAG_W +: MAG_W], NORM_SHIFT'(0)}
               + NUM_W'(sq_root[SQ_N] >> 1);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[0][i] <= DREM_W'(num[NUM_W-1:DIV_N]);
        dv_low[0][i] <= num[DIV_N-1:0];
        dv_q[0][i]   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_div[0] <= sq_root[SQ_N];
      dv_sgn[0] <= sq_sgn[SQ_N];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [DREM_W-1:0] r_t;
      logic              ge;
      assign r_t = {dv_rem[k][i][DREM_W-2:0], dv_low[k][i][DIV_N-1]};
      assign ge  = (r_t >= {1'b0, dv_div[k]});
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[k+1][i] <= ge ? (r_t - {1'b0, dv_div[k]}) : r_t;
          dv_low[k+1][i] <= dv_low[k][i] << 1;
          dv_q[k+1][i]   <= {dv_q[k][i][DIV_N-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_div[k+1] <= dv_div[k];
        dv_sgn[k+1] <= dv_sgn[k];
      end
    end
  end

  // saturate and apply sign
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [DIV_N-1:0] sat;
    logic [HGT_W-1:0] res;
    assign sat = (dv_q[DIV_N][i] > DIV_N'(Q14_ONE)) ? DIV_N'(Q14_ONE) : dv_q[DIV_N][i];
    assign res = dv_sgn[DIV_N][i] ? (~HGT_W'(sat) + 1'b1) : HGT_W'(sat);
    if (i == 0) begin : g_x
      assign nx = $signed(res);
    end else if (i == 1) begin : g_y
      assign ny = $signed(res);
    end else begin : g_z
      assign nz = $signed(res);
    end
  end

endmodule

>>> design/hmsn_back.sv
// Back end: issues bank reads and writes, computes bilinear samples and
// neighbour vectors, and holds the output register. Depends on hmsn_pkg,
// hmsn_ram and hmsn_norm.
module hmsn_back import hmsn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cls_t              q_item,
  output logic              q_pop,
  output logic              nrm_phase,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  output logic [USER_W-1:0] out_tuser
);

  typedef struct packed {
    logic vld;
    logic hold;
    cls_t it;
  } m1_t;

  logic              adv, issue, is_norm;
  logic              phase_r, phase_nxt;
  logic [CELL_W-1:0] xo, yo;
  logic [HGT_W-1:0]  rd_data [BANKS];
  m1_t               m1_r, m1_nxt;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic [USER_W-1:0] out_user_r;

  // whole pipeline moves when the output register can take an item
  assign adv     = !out_valid_r || out_tready;
  assign is_norm = (q_item.kind == KIND_NORMAL);
  assign issue   = adv && q_valid;
  assign q_pop   = issue && (!is_norm || phase_r);
  assign nrm_phase = phase_r;

  // normal items take two issue slots: centre, west, south, then east, north
  assign phase_nxt = (issue && is_norm) ? !phase_r : phase_r;
  assign xo = (is_norm && !phase_r) ? q_item.x - 1'b1 : q_item.x + 1'b1;
  assign yo = (is_norm && !phase_r) ? q_item.y - 1'b1 : q_item.y + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // four banks by row and column parity
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    localparam logic BX = ((b % 2) == 1);
    localparam logic BY = ((b / 2) == 1);
    logic [CELL_W-1:0] xs, ys;
    logic              we;
    assign xs = (q_item.x[0] == BX) ? q_item.x : xo;
    assign ys = (q_item.y[0] == BY) ? q_item.y : yo;
    assign we = issue && (q_item.kind == KIND_WRITE) &&
                (q_item.x[0] == BX) && (q_item.y[0] == BY);
    hmsn_ram #(
      .WIDTH (HGT_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr ({q_item.y[CELL_W-1:1], q_item.x[CELL_W-1:1]}),
      .wdata (q_item.hv),
      .re    (adv),
      .raddr ({ys[CELL_W-1:1], xs[CELL_W-1:1]}),
      .rdata (rd_data[b])
    );
  end

  // item beside the read data
  always_comb begin
    m1_nxt.vld  = issue && (!is_norm || phase_r);
    m1_nxt.hold = issue && is_norm && !phase_r;
    m1_nxt.it   = q_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= '0;
    end else if (adv) begin
      m1_r <= m1_nxt;
    end
  end

  // bank selection for corners and neighbours
  logic              x0, y0;
  logic [1:0]        b11, b21, b12, b22, bc, bw, bs;
  assign x0  = m1_r.it.x[0];
  assign y0  = m1_r.it.y[0];
  assign b11 = {y0, x0};
  assign b21 = {y0, x0 ^ m1_r.it.x_alt};
  assign b12 = {y0 ^ m1_r.it.y_alt, x0};
  assign b22 = {y0 ^ m1_r.it.y_alt, x0 ^ m1_r.it.x_alt};
  assign bc  = {y0, x0};
  assign bw  = {!y0, x0};
  assign bs  = {y0, !x0};

  // hold centre, west and south between the two normal slots
  logic [HGT_W-1:0] c_r, w_r, s_r;
  always_ff @(posedge clk) begin
    if (adv && m1_r.hold) begin
      c_r <= rd_data[bc];
      w_r <= rd_data[bw];
      s_r <= rd_data[bs];
    end
  end

  // sum the triangle normals
  logic signed [HGT_W:0]   d_wc, d_ce, d_sc, d_cn;
  logic                    t1, t2, t3, t4;
  logic [2:0]              tri_cnt;
  logic signed [VEC_W-1:0] vx_sum, vz_sum;
  logic [VY_W-1:0]         vy_sum;
  logic [HGT_W-1:0]        e_v, n_v;

  assign e_v  = rd_data[bw];
  assign n_v  = rd_data[bs];
  assign d_wc = $signed({w_r[HGT_W-1], w_r}) - $signed({c_r[HGT_W-1], c_r});
  assign d_ce = $signed({c_r[HGT_W-1], c_r}) - $signed({e_v[HGT_W-1], e_v});
  assign d_sc = $signed({s_r[HGT_W-1], s_r}) - $signed({c_r[HGT_W-1], c_r});
  assign d_cn = $signed({c_r[HGT_W-1], c_r}) - $signed({n_v[HGT_W-1], n_v});
  assign t1   = m1_r.it.has_w && m1_r.it.has_n;
  assign t2   = m1_r.it.has_e && m1_r.it.has_n;
  assign t3   = m1_r.it.has_e && m1_r.it.has_s;
  assign t4   = m1_r.it.has_w && m1_r.it.has_s;
  assign tri_cnt = 3'(t1) + 3'(t2) + 3'(t3) + 3'(t4);
  assign vy_sum  = {tri_cnt, FRAC_W'(0)};
  assign vx_sum  = (t1 ? VEC_W'(d_wc) : '0) + (t2 ? VEC_W'(d_ce) : '0)
                 + (t3 ? VEC_W'(d_ce) : '0) + (t4 ? VEC_W'(d_wc) : '0);
  assign vz_sum  = (t1 ? VEC_W'(d_cn) : '0) + (t2 ? VEC_W'(d_cn) : '0)
                 + (t3 ? VEC_W'(d_sc) : '0) + (t4 ? VEC_W'(d_sc) : '0);

  logic signed [HGT_W-1:0] nx, ny, nz;
  hmsn_norm u_norm (
    .clk (clk),
    .en  (adv),
    .vx  (vx_sum),
    .vy  (vy_sum),
    .vz  (vz_sum),
    .nx  (nx),
    .ny  (ny),
    .nz  (nz)
  );

  // bilinear: weight along x, then along y
  logic [FRAC_W:0]   wx1, wx0, wy1, wy0;
  assign wx1 = {1'b0, m1_r.it.fx};
  assign wx0 = (FRAC_W+1)'(ONE_Q8) - wx1;

  tag_t                 tag1_r, tag2_r, tag3_r;
  logic signed [25:0]   p11_r, p21_r, p12_r, p22_r, a_r, b_r;
  logic signed [33:0]   ma_r, mb_r, acc;
  logic [FRAC_W-1:0]    fy1_r, fy2_r;
  logic [HGT_W-1:0]     hgt;
  tag_t                 tag_nxt, sb_in, sb_r [0:SB_N-1];

  always_comb begin
    tag_nxt.vld     = m1_r.vld;
    tag_nxt.kind    = m1_r.it.kind;
    tag_nxt.oor     = m1_r.it.oor;
    tag_nxt.zero_pt = m1_r.it.zero_pt;
    tag_nxt.border  = m1_r.it.border;
    tag_nxt.height  = '0;
  end

  assign wy1 = {1'b0, fy2_r};
  assign wy0 = (FRAC_W+1)'(ONE_Q8) - wy1;

  always_ff @(posedge clk) begin
    if (adv) begin
      p11_r <= $signed(rd_data[b11]) * $signed({1'b0, wx0});
      p21_r <= $signed(rd_data[b21]) * $signed({1'b0, wx1});
      p12_r <= $signed(rd_data[b12]) * $signed({1'b0, wx0});
      p22_r <= $signed(rd_data[b22]) * $signed({1'b0, wx1});
      fy1_r <= m1_r.it.fy;
      a_r   <= p11_r + p21_r;
      b_r   <= p12_r + p22_r;
      fy2_r <= fy1_r;
      ma_r  <= a_r * $signed({1'b0, wy0});
      mb_r  <= b_r * $signed({1'b0, wy1});
    end
  end

  // truncate toward zero
  assign acc = ma_r + mb_r;
  always_comb begin
    if (acc[33]) begin
      hgt = HGT_W'((acc + 34'sd65535) >>> 16);
    end else begin
      hgt = HGT_W'(acc >>> 16);
    end
  end

  // merge the sample height into the sideband
  always_comb begin
    sb_in = tag3_r;
    if (tag3_r.kind == KIND_SAMPLE && !tag3_r.oor && !tag3_r.zero_pt) begin
      sb_in.height = hgt;
    end
  end

  // sideband delay matched to the normal pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      for (int k = 0; k < SB_N; k++) sb_r[k] <= '0;
    end else if (adv) begin
      tag1_r <= tag_nxt;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      sb_r[0] <= sb_in;
      for (int k = 1; k < SB_N; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // output register
  tag_t              last;
  logic [OUT_W-1:0]  data_nxt;
  logic [USER_W-1:0] user_nxt;
  assign last = sb_r[SB_N-1];

  always_comb begin
    data_nxt = '0;
    user_nxt = '0;
    case (last.kind)
      KIND_SAMPLE: begin
        data_nxt[HGT_W-1:0] = last.height;
        user_nxt = last.oor ? 2'b11 : {!last.border, last.border};
      end
      KIND_NORMAL: begin
        if (!last.oor) data_nxt = {nz, ny, nx, HGT_W'(0)};
      end
      default: begin
        data_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= data_nxt;
      out_user_r <= user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> design/heightmap_sample_and_normal.sv
// Heightmap sampler and surface-normal unit: top level with the grid
// registers, front end, queue and back end. Depends on hmsn_pkg and all
// hmsn_* modules.
//
// Write and sample items are issued one per clock while the back end does
// not stall; a normal item is issued in two phases, because its east and
// west (and north and south) neighbours sit in the same one of the four
// parity-split height banks, whose single read port allows one access each
// per cycle. Every item yields one result once it has passed the queue, the
// bank read, and a 47-register arithmetic pipeline set by the 27-step square
// root and 16-step dividers of the normal path; samples ride a matched delay
// line so results stay in order. The whole back end stalls only while a
// result waits in the output register. The height store is not cleared:
// load every cell in use before reading it.
module heightmap_sample_and_normal import hmsn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // fields from bit 0: operation[1:0], coord_x[17:2], coord_y[33:18],
  // height_value[49:34], zero fill
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  // fields from bit 0: height, normal_x, normal_y, normal_z
  output logic [OUT_W-1:0]  out_tdata,
  // fields from bit 0: solid, penetrable
  output logic [USER_W-1:0] out_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DIM_W-1:0]  cfg_wdata
);

  logic [DIM_W-1:0] grid_width_r, grid_height_r;
  cls_t             front_item, q_head;
  logic             q_full, q_valid, q_pop, q_push, nrm_phase;

  // grid size registers, clamped on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(MAX_DIM);
      grid_height_r <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= clamp_dim(cfg_wdata);
        REG_GRID_HEIGHT: grid_height_r <= clamp_dim(cfg_wdata);
        default: grid_width_r <= grid_width_r;
      endcase
    end
  end

  hmsn_front u_front (
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .op          (in_tdata[OP_W-1:0]),
    .cx          (in_tdata[OP_W +: CRD_W]),
    .cy          (in_tdata[OP_W+CRD_W +: CRD_W]),
    .hv          (in_tdata[OP_W+2*CRD_W +: HGT_W]),
    .item        (front_item)
  );

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  hmsn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  hmsn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .nrm_phase  (nrm_phase),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // second normal slot only ever follows a normal at the queue head
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    nrm_phase |-> (q_valid && q_head.kind == KIND_NORMAL))
    else $error("normal second slot without a normal at the queue head");

  // both flags only for an out-of-range sample, whose height is zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] && out_tuser[1]) |-> (out_tdata[HGT_W-1:0] == '0))
    else $error("out-of-range sample with nonzero height");

  // a normal result carries no height and no flags
  a_normal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[OUT_W-1:HGT_W] != '0) |->
      (out_tuser == '0 && out_tdata[HGT_W-1:0] == '0))
    else $error("normal result mixed with sample fields");

endmodule
